@@ hw/rtl/afhsp_pkg.sv @@
// Package with the shared types, codes and rate tables of the frame header parser.
`timescale 1ns / 1ps

package afhsp_pkg;

  localparam int unsigned SyncBits   = 12;
  localparam int unsigned HeaderBits = 20;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusBad    = 2'd1;
  localparam logic [1:0] StatusNoSync = 2'd2;

  localparam logic [1:0] ModeJoint = 2'd1;
  localparam logic [1:0] ModeMono  = 2'd3;

  localparam logic [1:0] LayBitsReserved = 2'd0;
  localparam logic [1:0] LayBitsLayer3   = 2'd1;
  localparam logic [3:0] BitrateBad      = 4'd15;
  localparam logic [1:0] RateReserved    = 2'd3;
  localparam logic [1:0] Rate44k1        = 2'd0;
  localparam logic [1:0] Rate48k         = 2'd1;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [5:0]        misc_bits;
    logic [2:0]        layer_number;
    logic              crc_present;
    logic [3:0]        bitrate_code;
    logic [1:0]        sample_rate_index;
    logic              padding;
    logic [1:0]        mode;
    logic [1:0]        mode_extension;
    logic [1:0]        channels;
    logic [5:0]        joint_bound;
    logic signed [11:0] data_slots;
  } out_item_t;

  // One queue entry: either a complete header or a no-sync marker.
  typedef struct packed {
    logic                    no_sync;
    logic [HeaderBits-1:0]   header;
  } hdr_entry_t;

  // floor(144 * bitrate / freq) for the layer III bitrate table.
  function automatic logic [10:0] frame_base(input logic [3:0] bri, input logic [1:0] sri);
    logic [10:0] r44;
    logic [10:0] r48;
    logic [10:0] r32;
    unique case (bri)
      4'd1:    begin r44 = 11'd104;  r48 = 11'd96;  r32 = 11'd144;  end
      4'd2:    begin r44 = 11'd130;  r48 = 11'd120; r32 = 11'd180;  end
      4'd3:    begin r44 = 11'd156;  r48 = 11'd144; r32 = 11'd216;  end
      4'd4:    begin r44 = 11'd182;  r48 = 11'd168; r32 = 11'd252;  end
      4'd5:    begin r44 = 11'd208;  r48 = 11'd192; r32 = 11'd288;  end
      4'd6:    begin r44 = 11'd261;  r48 = 11'd240; r32 = 11'd360;  end
      4'd7:    begin r44 = 11'd313;  r48 = 11'd288; r32 = 11'd432;  end
      4'd8:    begin r44 = 11'd365;  r48 = 11'd336; r32 = 11'd504;  end
      4'd9:    begin r44 = 11'd417;  r48 = 11'd384; r32 = 11'd576;  end
      4'd10:   begin r44 = 11'd522;  r48 = 11'd480; r32 = 11'd720;  end
      4'd11:   begin r44 = 11'd626;  r48 = 11'd576; r32 = 11'd864;  end
      4'd12:   begin r44 = 11'd731;  r48 = 11'd672; r32 = 11'd1008; end
      4'd13:   begin r44 = 11'd835;  r48 = 11'd768; r32 = 11'd1152; end
      4'd14:   begin r44 = 11'd1044; r48 = 11'd960; r32 = 11'd1440; end
      default: begin r44 = 11'd0;    r48 = 11'd0;   r32 = 11'd0;    end
    endcase
    if (sri == Rate44k1) begin
      return r44;
    end else if (sri == Rate48k) begin
      return r48;
    end else begin
      return r32;
    end
  endfunction

endpackage

@@ hw/rtl/afhsp_front.sv @@
// Front end: sync word search and header byte collection.
`timescale 1ns / 1ps

module afhsp_front
  import afhsp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SyncBits-1:0] cfg_wdata_i,
  input  logic                fire_i,
  input  in_item_t            item_i,
  output logic                push_o,
  output hdr_entry_t          push_data_o
);

  typedef enum logic [3:0] {
    ST_SEARCH0 = 4'b0001,
    ST_SEARCH1 = 4'b0010,
    ST_HDR0    = 4'b0100,
    ST_HDR1    = 4'b1000
  } front_state_e;

  front_state_e        state_q, state_d;
  logic [23:0]         window_q, window_d;
  logic [SyncBits-1:0] sync_q;
  logic [23:0]         shifted;

  assign shifted = {window_q[15:0], item_i.stream_byte};

  always_comb begin
    state_d     = state_q;
    window_d    = window_q;
    push_o      = 1'b0;
    push_data_o = '{no_sync: 1'b1, header: '0};
    if (fire_i) begin
      window_d = shifted;
      unique case (state_q)
        ST_SEARCH0, ST_SEARCH1: begin
          if (item_i.stream_end) begin
            push_o = 1'b1;
          end else if (state_q == ST_SEARCH1 && shifted[15:4] == sync_q) begin
            state_d = ST_HDR0;
          end else begin
            state_d = ST_SEARCH1;
          end
        end
        ST_HDR0: begin
          if (item_i.stream_end) begin
            push_o = 1'b1;
          end else begin
            state_d = ST_HDR1;
          end
        end
        ST_HDR1: begin
          // The byte that completes the header wins even when it ends the stream.
          push_o      = 1'b1;
          push_data_o = '{no_sync: 1'b0, header: shifted[HeaderBits-1:0]};
        end
        default: state_d = ST_SEARCH0;
      endcase
      if (push_o) begin
        state_d  = ST_SEARCH0;
        window_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_SEARCH0;
      window_q <= '0;
      sync_q   <= '1;
    end else begin
      state_q  <= state_d;
      window_q <= window_d;
      if (cfg_we_i) begin
        sync_q <= cfg_wdata_i;
      end
    end
  end

endmodule

@@ hw/rtl/afhsp_queue.sv @@
// Small register queue between the front end and the decoder.
`timescale 1ns / 1ps

module afhsp_queue
  import afhsp_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  hdr_entry_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output hdr_entry_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hdr_entry_t      slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = slots_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not follow a lone write");

endmodule

@@ hw/rtl/afhsp_back.sv @@
// Back end: header field decode, slot count and output register.
`timescale 1ns / 1ps

module afhsp_back
  import afhsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  hdr_entry_t entry_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o
);

  logic       valid_q;
  out_item_t  item_q, item_d;
  logic [HeaderBits-1:0] h;
  logic [1:0] lay_bits;
  logic [1:0] mode;
  logic [1:0] mext;
  logic       bad;
  logic [5:0] bound;
  logic signed [11:0] slots;

  assign h        = entry_i.header;
  assign lay_bits = h[18:17];
  assign mode     = h[7:6];
  assign mext     = h[5:4];
  assign bad      = (lay_bits == LayBitsReserved) || (h[15:12] == BitrateBad)
                 || (h[11:10] == RateReserved);

  always_comb begin
    bound = 6'd32;
    if (mode == ModeJoint && lay_bits != LayBitsReserved) begin
      if (lay_bits == LayBitsLayer3) begin
        bound = (mext == 2'd0) ? 6'd0 : (mext == 2'd1) ? 6'd4 : (mext == 2'd2) ? 6'd8 : 6'd16;
      end else begin
        bound = {2'b00, mext, 2'b00} + 6'd4;
      end
    end
  end

  // Side info is 17 bytes for mono and 32 otherwise; a CRC takes two more.
  always_comb begin
    slots = $signed({1'b0, frame_base(h[15:12], h[11:10])}) + $signed({11'd0, h[9]})
          - 12'sd4 - (h[16] ? 12'sd0 : 12'sd2) - ((mode == ModeMono) ? 12'sd17 : 12'sd32);
    if (bad) begin
      slots = '0;
    end
  end

  always_comb begin
    item_d = '0;
    if (entry_i.no_sync) begin
      item_d.status = StatusNoSync;
    end else begin
      item_d.status            = bad ? StatusBad : StatusOk;
      item_d.misc_bits         = {h[19], h[8], h[3], h[2], h[1:0]};
      item_d.layer_number      = 3'd4 - {1'b0, lay_bits};
      item_d.crc_present       = ~h[16];
      item_d.bitrate_code      = h[15:12];
      item_d.sample_rate_index = h[11:10];
      item_d.padding           = h[9];
      item_d.mode              = mode;
      item_d.mode_extension    = mext;
      item_d.channels          = (mode == ModeMono) ? 2'd1 : 2'd2;
      item_d.joint_bound       = bound;
      item_d.data_slots        = slots;
    end
  end

  assign pop_o       = !empty_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/audio_frame_header_sync_parser.sv @@
// Top level of the frame header sync parser: front end, queue and decoder.
// Throughput: one stream byte per cycle, with at most one result per byte.
// A result is queued at the edge that takes the byte that causes it, and is then loaded into
// the decoder output register once that register is empty or being read.
// The input stalls only when the header queue is full, which, for a queue depth above one, takes a stalled output.
// Reset clears the search state, empties the queue and sets the sync word to all ones.
`timescale 1ns / 1ps

module audio_frame_header_sync_parser
  import afhsp_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [SyncBits-1:0] cfg_wdata_i
);

  logic       fire;
  logic       push;
  hdr_entry_t push_data;
  logic       full;
  logic       pop;
  logic       empty;
  hdr_entry_t head;

  assign in_ready_o = !full;
  assign fire       = in_valid_i && !full;

  afhsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (in_item_i),
    .push_o      (push),
    .push_data_o (push_data)
  );

  afhsp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (head)
  );

  afhsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
